/* hw/rtl/rtn_pkg.sv */
// ----------------------------------------------------------------------------
// rtn_pkg
// Shared types and constants for the RGB to NV12 packer: beat payloads,
// register indexes and the fixed widths of positions and dimensions.
// ----------------------------------------------------------------------------
package rtn_pkg;

    // Configuration register file
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE  = 2'd2;

    // Positions cover the largest supported frame (8192), dimensions hold 8192 itself.
    localparam int POS_W = 13;
    localparam int DIM_W = 14;

    // Queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Division by 1000 as multiply by ceil(2^26/1000) and shift; exact below 2^18.
    localparam int          SUM_W       = 18;
    localparam int          RECIP_W     = 17;
    localparam int          RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 17'd67109;
    localparam int          PROD_W      = SUM_W + RECIP_W;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [23:0] luma_addr;
        logic [7:0]  luma_value;
        logic        chroma_valid;
        logic [24:0] chroma_addr;
        logic [7:0]  cb_value;
        logic [7:0]  cr_value;
        logic        frame_last;
    } t_pix_out;

    // A pixel after classification by the front end
    typedef struct packed {
        t_pix_in          pix;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             chroma;
        logic             last;
    } t_pix_tag;

endpackage

/* hw/rtl/rtn_front.sv */
// ----------------------------------------------------------------------------
// rtn_front
// Accepts pixels, keeps the raster position and tags each pixel with its
// position, chroma eligibility and end of frame.
// ----------------------------------------------------------------------------
module rtn_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [rtn_pkg::DIM_W-1:0]    i_eff_width,
    input  logic [rtn_pkg::DIM_W-1:0]    i_eff_height,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  rtn_pkg::t_pix_in             i_pix,
    output logic                         o_push,
    output rtn_pkg::t_pix_tag            o_tag,
    input  logic                         i_queue_ready
);
    import rtn_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] col_d, row_d;
    logic             line_end, last, chroma, accept;

    always_comb begin
        col_d    = DIM_W'(r_col);
        row_d    = DIM_W'(r_row);
        line_end = col_d >= (i_eff_width - DIM_W'(1));
        last     = line_end && (row_d >= (i_eff_height - DIM_W'(1)));
        // Only the even-sized part of the frame carries chroma.
        chroma   = r_col[0] && r_row[0] &&
                   (col_d < {i_eff_width[DIM_W-1:1], 1'b0}) &&
                   (row_d < {i_eff_height[DIM_W-1:1], 1'b0});
    end

    assign accept  = i_valid && i_queue_ready;
    assign o_ready = i_queue_ready;
    assign o_push  = accept;

    always_comb begin
        o_tag.pix    = i_pix;
        o_tag.col    = POS_W'(r_col);
        o_tag.row    = POS_W'(r_row);
        o_tag.chroma = chroma;
        o_tag.last   = last;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (line_end) begin
                n_col = '0;
                n_row = last ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

/* hw/rtl/rtn_queue.sv */
// ----------------------------------------------------------------------------
// rtn_queue
// Short first-in first-out queue of tagged pixels between front and back end.
// ----------------------------------------------------------------------------
module rtn_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rtn_pkg::t_pix_tag i_tag,
    output logic              o_ready,
    output logic              o_valid,
    output rtn_pkg::t_pix_tag o_tag,
    input  logic              i_pop
);
    import rtn_pkg::*;

    t_pix_tag           r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push, do_pop;

    assign o_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_tag   = r_entry[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

/* hw/rtl/rtn_back.sv */
// ----------------------------------------------------------------------------
// rtn_back
// Three-stage pipeline that turns tagged pixels into luma, chroma and their
// byte addresses: weighted sums and address products, reciprocal multiply,
// then quotient selection into the output register.
// ----------------------------------------------------------------------------
module rtn_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [rtn_pkg::CFG_W-1:0] i_stride,
    input  logic [rtn_pkg::DIM_W-1:0] i_eff_height,
    input  logic                      i_valid,
    output logic                      o_pop,
    input  rtn_pkg::t_pix_tag         i_tag,
    output logic                      o_valid,
    input  logic                      i_ready,
    output rtn_pkg::t_pix_out         o_res
);
    import rtn_pkg::*;

    localparam int LPROD_W = POS_W + CFG_W;
    localparam int LSUM_W  = LPROD_W + 1;
    localparam int CROW_W  = DIM_W + 1;
    localparam int CPROD_W = CROW_W + CFG_W;
    localparam int CSUM_W  = CPROD_W + 1;
    localparam int SGN_W   = 20;

    // Stage 1: sums and address products
    logic                  r_v1;
    logic [SUM_W-1:0]      r_y_sum, r_cb_sum, r_cr_sum;
    logic [LPROD_W-1:0]    r_lprod;
    logic [CPROD_W-1:0]    r_cprod;
    logic [POS_W-1:0]      r_col1;
    logic                  r_chroma1, r_last1;

    // Stage 2: reciprocal products and final addresses
    logic                  r_v2;
    logic [PROD_W-1:0]     r_y_prod, r_cb_prod, r_cr_prod;
    logic [23:0]           r_laddr;
    logic [24:0]           r_caddr;
    logic                  r_chroma2, r_last2;

    // Stage 3: output register
    logic                  r_v3;
    t_pix_out              r_res;

    logic rdy1, rdy2, rdy3;

    assign rdy3  = !r_v3 || i_ready;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign o_pop = rdy1 && i_valid;

    // Stage 1 arithmetic
    logic [SGN_W-1:0]   r20, g20, b20;
    logic [SGN_W-1:0]   y_s, cb_s, cr_s;
    logic [CROW_W-1:0]  crow;

    always_comb begin
        r20  = SGN_W'(i_tag.pix.red);
        g20  = SGN_W'(i_tag.pix.green);
        b20  = SGN_W'(i_tag.pix.blue);
        y_s  = r20 * SGN_W'(257) + g20 * SGN_W'(504) + b20 * SGN_W'(98) + SGN_W'(16000);
        cb_s = b20 * SGN_W'(439) + SGN_W'(128000) - r20 * SGN_W'(148) - g20 * SGN_W'(291);
        cr_s = r20 * SGN_W'(439) + SGN_W'(128000) - g20 * SGN_W'(368) - b20 * SGN_W'(71);
        // Chroma plane base folded in: stride * (height + row / 2).
        crow = CROW_W'(i_eff_height) + CROW_W'(i_tag.row[POS_W-1:1]);
    end

    function automatic logic [SUM_W-1:0] clip_neg(input logic [SGN_W-1:0] s);
        logic [SUM_W-1:0] v;
        if (s[SGN_W-1]) begin
            v = '0;
        end else if (s[SGN_W-2:SUM_W] != '0) begin
            v = '1;
        end else begin
            v = s[SUM_W-1:0];
        end
        return v;
    endfunction

    function automatic logic [7:0] quot(input logic [PROD_W-1:0] p);
        logic [PROD_W-RECIP_SHIFT-1:0] q;
        q = p[PROD_W-1:RECIP_SHIFT];
        return (q > (PROD_W-RECIP_SHIFT)'(255)) ? 8'd255 : q[7:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_y_sum   <= clip_neg(y_s);
            r_cb_sum  <= clip_neg(cb_s);
            r_cr_sum  <= clip_neg(cr_s);
            r_lprod   <= LPROD_W'(i_tag.row) * LPROD_W'(i_stride);
            r_cprod   <= CPROD_W'(crow) * CPROD_W'(i_stride);
            r_col1    <= i_tag.col;
            r_chroma1 <= i_tag.chroma;
            r_last1   <= i_tag.last;
        end
        if (rdy2) begin
            r_y_prod  <= PROD_W'(r_y_sum) * PROD_W'(RECIP_1000);
            r_cb_prod <= PROD_W'(r_cb_sum) * PROD_W'(RECIP_1000);
            r_cr_prod <= PROD_W'(r_cr_sum) * PROD_W'(RECIP_1000);
            r_laddr   <= 24'(LSUM_W'(r_lprod) + LSUM_W'(r_col1));
            r_caddr   <= r_chroma1 ?
                         25'(CSUM_W'(r_cprod) + CSUM_W'({r_col1[POS_W-1:1], 1'b0})) : '0;
            r_chroma2 <= r_chroma1;
            r_last2   <= r_last1;
        end
        if (rdy3) begin
            r_res.luma_addr    <= r_laddr;
            r_res.luma_value   <= quot(r_y_prod);
            r_res.chroma_valid <= r_chroma2;
            r_res.chroma_addr  <= r_caddr;
            r_res.cb_value     <= r_chroma2 ? quot(r_cb_prod) : 8'd0;
            r_res.cr_value     <= r_chroma2 ? quot(r_cr_prod) : 8'd0;
            r_res.frame_last   <= r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_valid = r_v3;
    assign o_res   = r_res;

endmodule

/* hw/rtl/rgb_to_nv12_packer.sv */
// An accepted pixel is written into the queue, then passes pipeline stages 1, 2 and 3 to the output.
// Throughput: one pixel per cycle while i_ready is high, set by the three-stage arithmetic pipeline.
// A four-beat queue between the position tracker and the pipeline absorbs stalls.
// Reset (synchronous, active low) clears the raster position and all valid state
// and loads the default 640x480 geometry with a 640-byte stride.
// ----------------------------------------------------------------------------
// rgb_to_nv12_packer
// Streams RGB pixels into limited-range BT.601 NV12 luma and interleaved
// chroma bytes, each with its byte address in the output buffer.
// ----------------------------------------------------------------------------
module rgb_to_nv12_packer #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rtn_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [rtn_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  rtn_pkg::t_pix_in              i_pix,
    output logic                          o_valid,
    input  logic                          i_ready,
    output rtn_pkg::t_pix_out             o_res
);
    import rtn_pkg::*;

    logic [CFG_W-1:0] r_frame_width, r_frame_height, r_line_stride;
    logic [DIM_W-1:0] eff_width, eff_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(640);
            r_frame_height <= CFG_W'(480);
            r_line_stride  <= CFG_W'(640);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                CFG_LINE_STRIDE:  r_line_stride  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A zero dimension counts as one; oversized ones saturate at the maximum.
    always_comb begin
        if (r_frame_width == '0) begin
            eff_width = DIM_W'(1);
        end else if (DIM_W'(r_frame_width) > DIM_W'(MAX_WIDTH)) begin
            eff_width = DIM_W'(MAX_WIDTH);
        end else begin
            eff_width = DIM_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_height = DIM_W'(1);
        end else if (DIM_W'(r_frame_height) > DIM_W'(MAX_HEIGHT)) begin
            eff_height = DIM_W'(MAX_HEIGHT);
        end else begin
            eff_height = DIM_W'(r_frame_height);
        end
    end

    logic     push, queue_ready, queue_valid, pop;
    t_pix_tag front_tag, queue_tag;

    rtn_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_eff_width   (eff_width),
        .i_eff_height  (eff_height),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pix         (i_pix),
        .o_push        (push),
        .o_tag         (front_tag),
        .i_queue_ready (queue_ready)
    );

    rtn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tag   (front_tag),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_tag   (queue_tag),
        .i_pop   (pop)
    );

    rtn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stride     (r_line_stride),
        .i_eff_height (eff_height),
        .i_valid      (queue_valid),
        .o_pop        (pop),
        .i_tag        (queue_tag),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_res        (o_res)
    );

endmodule
